// ===== design/nstp_pkg.sv =====
// Package for the nested scope timing profiler.
// Holds the sizes, event codes and the structs that the slot cells share.
// No dependencies.
package nstp_pkg;

  localparam int MaxScopes = 16;
  localparam int SlotW     = $clog2(MaxScopes);
  localparam int CntW      = $clog2(MaxScopes + 1);
  localparam int TickW     = 40;
  localparam int TagW      = 16;
  localparam int CallW     = 16;
  localparam int RetW      = 16;
  localparam int FracW     = 16;
  localparam int AvgW      = 56;
  localparam int ModeW     = 3;

  localparam logic [CntW-1:0] ScopesFull = CntW'(MaxScopes);

  localparam logic [ModeW-1:0] ModeBeginFrame = 3'd0;
  localparam logic [ModeW-1:0] ModeEndFrame   = 3'd1;
  localparam logic [ModeW-1:0] ModeBeginScope = 3'd2;
  localparam logic [ModeW-1:0] ModeEndScope   = 3'd3;
  localparam logic [ModeW-1:0] ModeClear      = 3'd4;

  // broadcast from the sequencer to every slot cell
  typedef struct packed {
    logic [SlotW-1:0] sel;
    logic [SlotW-1:0] rd_sel;
    logic [CntW-1:0]  used;
    logic [TagW-1:0]  tag;
    logic [TickW-1:0] now;
    logic [SlotW-1:0] depth;
    logic [TickW-1:0] elapsed;
    logic [AvgW-1:0]  avg;
    logic [TickW-1:0] peak;
    logic             clr_frame;
    logic             clr_stats;
    logic             claim;
    logic             enter;
    logic             acc;
    logic             wb;
  } cell_ctrl_t;

  // read bus handed along the chain of cells
  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [TickW-1:0] start;
    logic [TickW-1:0] total;
    logic [CallW-1:0] calls;
    logic [SlotW-1:0] depth;
    logic [AvgW-1:0]  avg;
    logic [TickW-1:0] peak;
  } cell_rd_t;

endpackage

// ===== design/nstp_cell.sv =====
// One table slot of the profiler: tag, entry time, frame totals and statistics.
// Passes the tag hit and the read bus on to its neighbor. Uses nstp_pkg.
module nstp_cell import nstp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SlotW-1:0] idx_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic             hit_i,
  input  logic [SlotW-1:0] hit_idx_i,
  output logic             hit_o,
  output logic [SlotW-1:0] hit_idx_o,
  input  cell_rd_t         rd_i,
  output cell_rd_t         rd_o
);

  logic [TagW-1:0]  tag_q, tag_d;
  logic [TickW-1:0] start_q, start_d;
  logic [TickW-1:0] total_q, total_d;
  logic [CallW-1:0] calls_q, calls_d;
  logic [SlotW-1:0] depth_q, depth_d;
  logic [AvgW-1:0]  avg_q, avg_d;
  logic [TickW-1:0] peak_q, peak_d;
  logic             me, used, match;
  logic [TickW:0]   sum;

  assign me    = (idx_i == ctrl_i.sel);
  assign used  = (CntW'(idx_i) < ctrl_i.used);
  assign match = used && (tag_q == ctrl_i.tag);
  assign sum   = {1'b0, total_q} + {1'b0, ctrl_i.elapsed};

  assign hit_o     = hit_i | match;
  assign hit_idx_o = hit_i ? hit_idx_i : idx_i;

  always_comb begin
    rd_o = rd_i;
    if (idx_i == ctrl_i.rd_sel) begin
      rd_o = '{tag: tag_q, start: start_q, total: total_q, calls: calls_q,
               depth: depth_q, avg: avg_q, peak: peak_q};
    end
  end

  always_comb begin
    tag_d   = tag_q;
    start_d = start_q;
    total_d = total_q;
    calls_d = calls_q;
    depth_d = depth_q;
    avg_d   = avg_q;
    peak_d  = peak_q;
    if (ctrl_i.clr_frame) begin
      total_d = '0;
      calls_d = '0;
    end
    if (ctrl_i.clr_stats) begin
      avg_d  = '0;
      peak_d = '0;
    end
    if (me) begin
      if (ctrl_i.claim) begin
        tag_d   = ctrl_i.tag;
        total_d = '0;
        calls_d = '0;
        depth_d = '0;
        avg_d   = '0;
        peak_d  = '0;
      end
      if (ctrl_i.enter) begin
        depth_d = ctrl_i.depth;
        start_d = ctrl_i.now;
        if (calls_d != '1) calls_d = calls_d + 1'b1;
      end
      if (ctrl_i.acc) begin
        total_d = sum[TickW] ? '1 : sum[TickW-1:0];
      end
      if (ctrl_i.wb) begin
        avg_d  = ctrl_i.avg;
        peak_d = ctrl_i.peak;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q   <= tag_d;
    start_q <= start_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      calls_q <= '0;
      depth_q <= '0;
      avg_q   <= '0;
      peak_q  <= '0;
    end else begin
      total_q <= total_d;
      calls_q <= calls_d;
      depth_q <= depth_d;
      avg_q   <= avg_d;
      peak_q  <= peak_d;
    end
  end

endmodule

// ===== design/nstp_stack.sv =====
// Stack of open scopes, holding slot numbers.
// Push, pop and reset to empty at begin frame. Uses nstp_pkg.
module nstp_stack import nstp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             push_i,
  input  logic             pop_i,
  input  logic [SlotW-1:0] data_i,
  output logic [CntW-1:0]  depth_o,
  output logic [SlotW-1:0] top_o
);

  logic [SlotW-1:0] mem_q [MaxScopes];
  logic [CntW-1:0]  depth_q;
  logic [SlotW-1:0] top_idx;

  assign top_idx = SlotW'(depth_q - 1'b1);
  assign top_o   = mem_q[top_idx];
  assign depth_o = depth_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[depth_q[SlotW-1:0]] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else if (clr_i) begin
      depth_q <= '0;
    end else if (push_i) begin
      depth_q <= depth_q + 1'b1;
    end else if (pop_i) begin
      depth_q <= depth_q - 1'b1;
    end
  end

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> depth_q < ScopesFull) else $error("push on full stack");
  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> depth_q != '0) else $error("pop on empty stack");
  a_depth_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !clr_i |=> depth_q == $past(depth_q) + 1'b1)
    else $error("stack depth did not advance on push");

endmodule

// ===== design/nstp_blend.sv =====
// Moving average update: registered partial products, then one sum.
// new = hi(avg)*r + (lo(avg)*r >> 16) + last*(65536-r). Uses nstp_pkg.
module nstp_blend import nstp_pkg::*; (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic [AvgW-1:0]  avg_i,
  input  logic [TickW-1:0] total_i,
  input  logic [RetW-1:0]  ret_i,
  output logic [AvgW-1:0]  avg_o
);

  logic [AvgW-1:0]         hi_q;
  logic [FracW-1:0]        lo_q;
  logic [TickW+RetW:0]     fresh_q;
  logic [2*FracW-1:0]      lo_prod;
  logic [RetW:0]           keep_c;
  logic [AvgW+1:0]         sum;

  assign lo_prod = avg_i[FracW-1:0] * ret_i;
  assign keep_c  = {1'b1, {RetW{1'b0}}} - {1'b0, ret_i};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      hi_q    <= AvgW'(avg_i[AvgW-1:FracW] * ret_i);
      lo_q    <= lo_prod[2*FracW-1:FracW];
      fresh_q <= total_i * keep_c;
    end
  end

  assign sum   = (AvgW+2)'(hi_q) + (AvgW+2)'(lo_q) + (AvgW+2)'(fresh_q);
  assign avg_o = sum[AvgW-1:0];

endmodule

// ===== design/nested_scope_timing_profiler.sv =====
// Top level of the nested scope timing profiler: sequencer, stack, blend unit
// and the chain of slot cells. Uses nstp_pkg, nstp_cell, nstp_stack, nstp_blend.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  mode, scope_tag, timestamp
//   out      output     out_valid_o/out_ready_i record fields, last
//   cfg      input      cfg_we_i               cfg_wdata_i (retention_q16)
//
// begin frame, begin scope and clear pass through EXEC only; end scope adds ACC (stack read and
// entry-time subtract in EXEC, then the saturating add in the cell in ACC).
// end frame sends the frame record from EXEC, then walks each used slot through MUL and WB for
// the blend multipliers; a stalled output beat holds the walk.
// reset empties the table, the stack and the frame; no clearing pass.
module nested_scope_timing_profiler import nstp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [RetW-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ModeW-1:0] mode_i,
  input  logic [TagW-1:0]  scope_tag_i,
  input  logic [TickW-1:0] timestamp_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             record_kind_o,
  output logic [SlotW-1:0] slot_index_o,
  output logic [TagW-1:0]  reported_tag_o,
  output logic [CallW-1:0] call_count_o,
  output logic [SlotW-1:0] nest_depth_o,
  output logic [TickW-1:0] last_ticks_o,
  output logic [AvgW-1:0]  average_ticks_o,
  output logic [TickW-1:0] peak_ticks_o,
  output logic             last_o
);

  typedef enum logic [2:0] {IDLE, EXEC, ACC, MUL, WB} state_e;

  state_e           state_q;
  logic [ModeW-1:0] mode_q;
  logic [TagW-1:0]  tag_q;
  logic [TickW-1:0] now_q;
  logic [CntW-1:0]  used_q;
  logic             in_frame_q;
  logic [TickW-1:0] fbegin_q;
  logic [RetW-1:0]  ret_q;
  logic [SlotW-1:0] k_q;
  logic [SlotW-1:0] slot_q;
  logic [TickW-1:0] elapsed_q;

  cell_ctrl_t       ctrl;
  logic             hit_c     [MaxScopes+1];
  logic [SlotW-1:0] hit_idx_c [MaxScopes+1];
  cell_rd_t         rd_c      [MaxScopes+1];
  cell_rd_t         rd;

  logic [CntW-1:0]  stk_depth;
  logic [SlotW-1:0] stk_top;
  logic             stk_push, stk_pop, stk_clr;
  logic [SlotW-1:0] new_slot;
  logic             do_claim, do_enter, out_free, wb_last;
  logic [AvgW-1:0]  blend_avg;
  logic [TickW-1:0] new_peak;

  assign hit_c[0]     = 1'b0;
  assign hit_idx_c[0] = '0;
  assign rd_c[0]      = '0;
  assign rd           = rd_c[MaxScopes];

  for (genvar i = 0; i < MaxScopes; i++) begin : g_cell
    nstp_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (SlotW'(i)),
      .ctrl_i    (ctrl),
      .hit_i     (hit_c[i]),
      .hit_idx_i (hit_idx_c[i]),
      .hit_o     (hit_c[i+1]),
      .hit_idx_o (hit_idx_c[i+1]),
      .rd_i      (rd_c[i]),
      .rd_o      (rd_c[i+1])
    );
  end

  nstp_stack u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (stk_clr),
    .push_i  (stk_push),
    .pop_i   (stk_pop),
    .data_i  (new_slot),
    .depth_o (stk_depth),
    .top_o   (stk_top)
  );

  nstp_blend u_blend (
    .clk_i   (clk_i),
    .load_i  (state_q == MUL),
    .avg_i   (rd.avg),
    .total_i (rd.total),
    .ret_i   (ret_q),
    .avg_o   (blend_avg)
  );

  assign out_free   = !out_valid_o || out_ready_i;
  assign in_ready_o = (state_q == IDLE);

  // known tag reuses its slot, else the next free one
  assign new_slot = hit_c[MaxScopes] ? hit_idx_c[MaxScopes] : used_q[SlotW-1:0];
  assign do_claim = !hit_c[MaxScopes] && (used_q < ScopesFull);
  assign do_enter = (hit_c[MaxScopes] || do_claim) && (stk_depth < ScopesFull);
  assign new_peak = (rd.total > rd.peak) ? rd.total : rd.peak;
  assign wb_last  = ((CntW'(k_q) + 1'b1) == used_q);

  assign stk_clr  = (state_q == EXEC) && (mode_q == ModeBeginFrame);
  assign stk_push = (state_q == EXEC) && (mode_q == ModeBeginScope) && do_enter;
  assign stk_pop  = (state_q == EXEC) && (mode_q == ModeEndScope) && (stk_depth != '0);

  always_comb begin
    ctrl         = '0;
    ctrl.sel     = k_q;
    ctrl.rd_sel  = k_q;
    ctrl.used    = used_q;
    ctrl.tag     = tag_q;
    ctrl.now     = now_q;
    ctrl.depth   = stk_depth[SlotW-1:0];
    ctrl.elapsed = elapsed_q;
    ctrl.avg     = blend_avg;
    ctrl.peak    = new_peak;
    case (state_q)
      EXEC: begin
        case (mode_q)
          ModeBeginFrame: ctrl.clr_frame = 1'b1;
          ModeBeginScope: begin
            ctrl.sel   = new_slot;
            ctrl.claim = do_claim;
            ctrl.enter = do_enter;
          end
          ModeEndScope: ctrl.rd_sel = stk_top;
          ModeClear:    ctrl.clr_stats = 1'b1;
          default: ;
        endcase
      end
      ACC: begin
        ctrl.sel = slot_q;
        ctrl.acc = 1'b1;
      end
      WB: ctrl.wb = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      used_q      <= '0;
      in_frame_q  <= 1'b0;
      fbegin_q    <= '0;
      ret_q       <= RetW'(58982);
      out_valid_o <= 1'b0;
      mode_q      <= '0;
      tag_q       <= '0;
      now_q       <= '0;
      k_q         <= '0;
      slot_q      <= '0;
      elapsed_q   <= '0;
      record_kind_o   <= 1'b0;
      slot_index_o    <= '0;
      reported_tag_o  <= '0;
      call_count_o    <= '0;
      nest_depth_o    <= '0;
      last_ticks_o    <= '0;
      average_ticks_o <= '0;
      peak_ticks_o    <= '0;
      last_o          <= 1'b0;
    end else begin
      if (cfg_we_i) ret_q <= cfg_wdata_i;
      if (out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        IDLE: begin
          if (in_valid_i) begin
            mode_q  <= mode_i;
            tag_q   <= scope_tag_i;
            now_q   <= timestamp_i;
            state_q <= EXEC;
          end
        end
        EXEC: begin
          state_q <= IDLE;
          case (mode_q)
            ModeBeginFrame: begin
              fbegin_q   <= now_q;
              in_frame_q <= 1'b1;
            end
            ModeBeginScope: begin
              if (do_claim) used_q <= used_q + 1'b1;
            end
            ModeEndScope: begin
              if (stk_depth != '0) begin
                slot_q    <= stk_top;
                elapsed_q <= now_q - rd.start;
                state_q   <= ACC;
              end
            end
            ModeEndFrame: begin
              if (in_frame_q) begin
                if (out_free) begin
                  in_frame_q      <= 1'b0;
                  out_valid_o     <= 1'b1;
                  record_kind_o   <= 1'b0;
                  slot_index_o    <= '0;
                  reported_tag_o  <= '0;
                  call_count_o    <= '0;
                  nest_depth_o    <= '0;
                  last_ticks_o    <= now_q - fbegin_q;
                  average_ticks_o <= '0;
                  peak_ticks_o    <= '0;
                  last_o          <= (used_q == '0);
                  k_q             <= '0;
                  state_q         <= (used_q == '0) ? IDLE : MUL;
                end else begin
                  state_q <= EXEC;
                end
              end
            end
            default: ;
          endcase
        end
        ACC: state_q <= IDLE;
        MUL: state_q <= WB;
        WB: begin
          if (out_free) begin
            out_valid_o     <= 1'b1;
            record_kind_o   <= 1'b1;
            slot_index_o    <= k_q;
            reported_tag_o  <= rd.tag;
            call_count_o    <= rd.calls;
            nest_depth_o    <= rd.depth;
            last_ticks_o    <= rd.total;
            average_ticks_o <= blend_avg;
            peak_ticks_o    <= new_peak;
            last_o          <= wb_last;
            k_q             <= k_q + 1'b1;
            state_q         <= wb_last ? IDLE : MUL;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

endmodule
